// File: rtl/det_pkg.sv
// Shared types, constants and register indexes for the difference edge threshold block.
package det_pkg;

   localparam int PIXEL_W    = 8;
   localparam int THRESH_W   = 9;
   localparam int WIDTH_W    = 12;
   localparam int HEIGHT_W   = 13;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int RSP_DATA_W = 32;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int QUEUE_DEPTH    = 4;

   localparam int THRESH_RESET = 10;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd2;

   localparam logic [PIXEL_W-1:0] PIX_EDGE = 8'd255;
   localparam logic [PIXEL_W-1:0] PIX_FLAT = 8'd0;

   typedef struct packed {
      logic [PIXEL_W-1:0] above;
      logic [PIXEL_W-1:0] right;
      logic [PIXEL_W-1:0] pix;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               last_col;
      logic               last_row;
   } queue_entry_type;

endpackage

// File: rtl/det_queue.sv
// Short register queue between the front and the back of the edge detector.
module det_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  det_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output det_pkg::queue_entry_type head_entry
);
   import det_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/det_front.sv
// Front end: raster counters, line store and classification of each accepted pixel.
module det_front #(
   parameter int MAX_WIDTH  = det_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = det_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [det_pkg::PIXEL_W-1:0]         req_tdata,
   input  logic [$clog2(MAX_WIDTH)-1:0]        col_last,
   input  logic [$clog2(MAX_HEIGHT)-1:0]       row_last,
   output logic                                push,
   output det_pkg::queue_entry_type            push_entry,
   input  logic                                queue_full
);
   import det_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [PIXEL_W-1:0] row_store [MAX_WIDTH];

   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic               accept;
   logic               is_last_col;
   logic               is_last_row;
   logic [CW-1:0]      right_addr;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_result_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic [PIXEL_W-1:0] s1_above_ff;
   logic [PIXEL_W-1:0] s1_right_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic               s1_last_col_ff;
   logic               s1_last_row_ff;
   logic               s1_advance;

   assign is_last_col = (col_ff >= col_last);
   assign is_last_row = (row_ff >= row_last);
   assign right_addr  = (col_ff == CW'(MAX_WIDTH - 1)) ? '0 : col_ff + 1'b1;

   assign s1_advance = s1_valid_ff && (!s1_result_ff || !queue_full);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept     = req_tvalid && req_tready;
   assign push       = s1_valid_ff && s1_result_ff;

   assign push_entry.above    = s1_above_ff;
   assign push_entry.right    = s1_right_ff;
   assign push_entry.pix      = s1_pix_ff;
   assign push_entry.row      = s1_row_ff;
   assign push_entry.col      = s1_col_ff;
   assign push_entry.last_col = s1_last_col_ff;
   assign push_entry.last_row = s1_last_row_ff;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         if (is_last_col) begin
            col_in = '0;
            row_in = is_last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_above_ff       <= row_store[col_ff];
         s1_right_ff       <= row_store[right_addr];
         row_store[col_ff] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_tdata;
         s1_result_ff   <= (row_ff != '0);
         s1_row_ff      <= ROW_W'(row_ff);
         s1_col_ff      <= COL_W'(col_ff);
         s1_last_col_ff <= is_last_col;
         s1_last_row_ff <= is_last_row;
      end
   end

endmodule

// File: rtl/det_back.sv
// Back end: gradient sum, threshold decision and output register with second-result handling.
module det_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [det_pkg::THRESH_W-1:0]     edge_threshold,
   input  logic                             queue_empty,
   input  det_pkg::queue_entry_type         head_entry,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [det_pkg::PIXEL_W-1:0]      out_pixel,
   output logic [det_pkg::ROW_W-1:0]        out_row,
   output logic [det_pkg::COL_W-1:0]        out_col,
   output logic                             frame_done,
   output logic                             run_last
);
   import det_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_pix_ff, out_pix_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic               out_done_ff, out_done_in;
   logic               out_last_ff, out_last_in;

   logic               pend_ff, pend_in;
   logic [PIXEL_W-1:0] pend_pix_ff, pend_pix_in;
   logic [ROW_W-1:0]   pend_row_ff, pend_row_in;
   logic [COL_W-1:0]   pend_col_ff, pend_col_in;
   logic               pend_done_ff, pend_done_in;

   logic               load;
   logic [PIXEL_W-1:0] diff_right;
   logic [PIXEL_W-1:0] diff_below;
   logic [THRESH_W-1:0] grad_sum;
   logic [PIXEL_W-1:0] first_pix;

   assign load = !out_valid_ff || rsp_tready;
   assign pop  = load && !pend_ff && !queue_empty;

   assign diff_right = (head_entry.above > head_entry.right) ?
                       head_entry.above - head_entry.right :
                       head_entry.right - head_entry.above;
   assign diff_below = (head_entry.above > head_entry.pix) ?
                       head_entry.above - head_entry.pix :
                       head_entry.pix - head_entry.above;
   assign grad_sum   = {1'b0, diff_right} + {1'b0, diff_below};
   assign first_pix  = head_entry.last_col ? head_entry.above :
                       ((grad_sum >= edge_threshold) ? PIX_EDGE : PIX_FLAT);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_pix_in   = out_pix_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_done_in  = out_done_ff;
      out_last_in  = out_last_ff;
      pend_in      = pend_ff;
      pend_pix_in  = pend_pix_ff;
      pend_row_in  = pend_row_ff;
      pend_col_in  = pend_col_ff;
      pend_done_in = pend_done_ff;
      if (load) begin
         if (pend_ff) begin
            out_valid_in = 1'b1;
            out_pix_in   = pend_pix_ff;
            out_row_in   = pend_row_ff;
            out_col_in   = pend_col_ff;
            out_done_in  = pend_done_ff;
            out_last_in  = 1'b1;
            pend_in      = 1'b0;
         end else if (!queue_empty) begin
            out_valid_in = 1'b1;
            out_pix_in   = first_pix;
            out_row_in   = head_entry.row - 1'b1;
            out_col_in   = head_entry.col;
            out_done_in  = 1'b0;
            out_last_in  = !head_entry.last_row;
            pend_in      = head_entry.last_row;
            pend_pix_in  = head_entry.pix;
            pend_row_in  = head_entry.row;
            pend_col_in  = head_entry.col;
            pend_done_in = head_entry.last_col;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pix_ff   <= out_pix_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_done_ff  <= out_done_in;
      out_last_ff  <= out_last_in;
      pend_pix_ff  <= pend_pix_in;
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      pend_done_ff <= pend_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign out_pixel  = out_pix_ff;
   assign out_row    = out_row_ff;
   assign out_col    = out_col_ff;
   assign frame_done = out_done_ff;
   assign run_last   = out_last_ff;

endmodule

// File: rtl/difference_edge_threshold.sv
// Top level of the difference edge threshold block: registers, front, queue and back.
//
//   channel | direction | handshake             | content
//   req     | in        | req_tvalid/req_tready | one grey pixel in raster order
//   rsp     | out       | rsp_tvalid/rsp_tready | edge or passed pixel with position
//   csr     | in        | csr_valid/csr_ready   | register index and write data
//
// One pixel is accepted every cycle while the queue is not full; a pixel in the last row
// yields two results, which the output port presents in turn while the queue absorbs the burst.
// A result passes the line store read register, the queue and the output register
// before it is presented.
// The line store has one write and two read addresses and is read and written in the
// same cycle. Reset clears the counters, queue and output; the line store is not cleared.
// A stall on the output side holds the input only once the queue is full.
module difference_edge_threshold #(
   parameter int MAX_WIDTH  = det_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = det_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_pixel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [det_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [7:0] out_pixel, [19:8] out_row,
                                                          // [30:20] out_col, [31] zero
   output logic                              rsp_tuser,   // [0] frame_done
   output logic                              rsp_tlast,   // run_last
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [det_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [det_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import det_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WLAST_RESET = ((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1;
   localparam int HLAST_RESET = ((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET) - 1;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [CW-1:0]       col_last_ff, col_last_in;
   logic [RW-1:0]       row_last_ff, row_last_in;
   logic                csr_write;
   logic [WIDTH_W-1:0]  width_raw;
   logic [HEIGHT_W-1:0] height_raw;
   logic [CW-1:0]       width_last;
   logic [RW-1:0]       height_last;

   logic                push;
   queue_entry_type     push_entry;
   logic                queue_full;
   logic                queue_empty;
   logic                pop;
   queue_entry_type     head_entry;

   logic [PIXEL_W-1:0]  out_pixel;
   logic [ROW_W-1:0]    out_row;
   logic [COL_W-1:0]    out_col;
   logic                frame_done;
   logic                run_last;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign width_raw  = csr_wdata[WIDTH_W-1:0];
   assign height_raw = csr_wdata[HEIGHT_W-1:0];

   always_comb begin
      if (width_raw < WIDTH_W'(2)) begin
         width_last = CW'(1);
      end else if (32'(width_raw) > 32'(MAX_WIDTH)) begin
         width_last = CW'(MAX_WIDTH - 1);
      end else begin
         width_last = CW'(width_raw - 1'b1);
      end
      if (height_raw < HEIGHT_W'(2)) begin
         height_last = RW'(1);
      end else if (32'(height_raw) > 32'(MAX_HEIGHT)) begin
         height_last = RW'(MAX_HEIGHT - 1);
      end else begin
         height_last = RW'(height_raw - 1'b1);
      end
   end

   always_comb begin
      thresh_in   = thresh_ff;
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD: thresh_in   = csr_wdata[THRESH_W-1:0];
            CSR_WIDTH:     col_last_in = width_last;
            CSR_HEIGHT:    row_last_in = height_last;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= THRESH_W'(THRESH_RESET);
         col_last_ff <= CW'(WLAST_RESET);
         row_last_ff <= RW'(HLAST_RESET);
      end else begin
         thresh_ff   <= thresh_in;
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
      end
   end

   det_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .col_last   (col_last_ff),
      .row_last   (row_last_ff),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   det_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_entry (head_entry)
   );

   det_back u_back (
      .clock          (clock),
      .reset          (reset),
      .edge_threshold (thresh_ff),
      .queue_empty    (queue_empty),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .out_pixel      (out_pixel),
      .out_row        (out_row),
      .out_col        (out_col),
      .frame_done     (frame_done),
      .run_last       (run_last)
   );

   assign rsp_tdata = {1'b0, out_col, out_row, out_pixel};
   assign rsp_tuser = frame_done;
   assign rsp_tlast = run_last;

endmodule
